@@ rtl/eatq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive threshold QRS marker: shared package
// Sizes, command and register codes, state encoding and the control and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package eatq_pkg;

    localparam int TRAIN_LEN   = 256;
    localparam int FRAME_LEN   = 256;
    localparam int SAMPLE_BITS = 16;

    localparam int ADDR_W = (TRAIN_LEN > 1) ? $clog2(TRAIN_LEN) : 1;
    localparam int FILL_W = $clog2(TRAIN_LEN + 1);
    localparam int POS_W  = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;

    localparam int SAMPLE_FIELD_W = 16;
    localparam int THR_W          = 15;
    localparam int COEF_W         = 16;
    localparam int CMD_W          = 2;
    localparam int CFG_IDX_W      = 1;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    localparam logic [COEF_W-1:0] Q15_ONE     = 16'h8000;
    localparam logic [COEF_W-1:0] ALPHA_RESET = 16'd1802;
    localparam logic [COEF_W-1:0] GAMMA_RESET = 16'd5734;
    localparam logic [THR_W-1:0]  PEAK_MAX    = 15'h7FFF;

    localparam logic [CMD_W-1:0] CMD_PUSH       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAIN      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEW_RECORD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT,
        ST_MUL_A,
        ST_MUL_B,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic capture;
        logic train_push;
        logic append_push;
        logic mem_read;
        logic emit;
        logic end_training;
        logic clear;
        logic mul_a;
        logic mul_b;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             line_empty;
        logic             line_full;
        logic             training_done;
        logic             out_free;
        logic             frame_close;
    } t_dp_sts;

endpackage

@@ rtl/eatq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive threshold QRS marker: controller
// Sequences each input beat through decode; a beat that reads the delay line
// then gets its mark decision and, at a frame close, two threshold multiplies.
// ----------------------------------------------------------------------------
module eatq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  eatq_pkg::t_dp_sts i_sts,
    output eatq_pkg::t_dp_cmd o_cmd
);

    eatq_pkg::t_state r_state;
    eatq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eatq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            eatq_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = eatq_pkg::ST_DECODE;
                end
            end
            eatq_pkg::ST_DECODE: begin
                n_state = eatq_pkg::ST_IDLE;
                if (i_sts.command == eatq_pkg::CMD_PUSH && i_sts.training_done
                        && i_sts.line_full) begin
                    n_state = eatq_pkg::ST_EMIT;
                end else if (i_sts.command == eatq_pkg::CMD_DRAIN && !i_sts.line_empty) begin
                    n_state = eatq_pkg::ST_EMIT;
                end
            end
            eatq_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.frame_close ? eatq_pkg::ST_MUL_A : eatq_pkg::ST_IDLE;
                end
            end
            eatq_pkg::ST_MUL_A:  n_state = eatq_pkg::ST_MUL_B;
            eatq_pkg::ST_MUL_B:  n_state = eatq_pkg::ST_UPDATE;
            eatq_pkg::ST_UPDATE: n_state = eatq_pkg::ST_IDLE;
            default:             n_state = eatq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            eatq_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                o_cmd.capture   = i_s_axis_tvalid;
            end
            eatq_pkg::ST_DECODE: begin
                case (i_sts.command)
                    eatq_pkg::CMD_PUSH: begin
                        if (!i_sts.training_done) begin
                            o_cmd.train_push = 1'b1;
                        end else if (i_sts.line_full) begin
                            o_cmd.mem_read = 1'b1;
                        end else begin
                            o_cmd.append_push = 1'b1;
                        end
                    end
                    eatq_pkg::CMD_DRAIN: begin
                        o_cmd.end_training = 1'b1;
                        o_cmd.mem_read     = !i_sts.line_empty;
                    end
                    eatq_pkg::CMD_NEW_RECORD: begin
                        o_cmd.clear = 1'b1;
                    end
                    default: begin
                        o_cmd = '0;
                    end
                endcase
            end
            eatq_pkg::ST_EMIT:   o_cmd.emit   = i_sts.out_free;
            eatq_pkg::ST_MUL_A:  o_cmd.mul_a  = 1'b1;
            eatq_pkg::ST_MUL_B:  o_cmd.mul_b  = 1'b1;
            eatq_pkg::ST_UPDATE: o_cmd.update = 1'b1;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/eatq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive threshold QRS marker: datapath
// Ring buffer delay line, training maximum, per-frame mark and peak logic,
// threshold update multipliers, configuration registers and output register.
// ----------------------------------------------------------------------------
module eatq_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [eatq_pkg::IN_TDATA_W-1:0]        i_s_axis_tdata,
    input  logic [eatq_pkg::CMD_W-1:0]             i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [eatq_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                                   o_m_axis_tuser,
    output logic                                   o_m_axis_tlast,
    input  logic                                   i_cfg_valid,
    input  logic [eatq_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [eatq_pkg::COEF_W-1:0]            i_cfg_data,
    input  eatq_pkg::t_dp_cmd                      i_cmd,
    output eatq_pkg::t_dp_sts                      o_sts
);

    localparam int SB  = eatq_pkg::SAMPLE_BITS;
    localparam int AW  = eatq_pkg::ADDR_W;
    localparam int FW  = eatq_pkg::FILL_W;
    localparam int TW  = eatq_pkg::THR_W;
    localparam int CW  = eatq_pkg::COEF_W;
    localparam int AGW = 2 * CW - 1;
    localparam int PTW = CW + TW;
    localparam int PPW = AGW + TW;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [FW-1:0] ofs);
        logic [FW:0] s;
        s = (FW + 1)'(base) + (FW + 1)'(ofs);
        if (s >= (FW + 1)'(eatq_pkg::TRAIN_LEN)) begin
            s = s - (FW + 1)'(eatq_pkg::TRAIN_LEN);
        end
        return s[AW-1:0];
    endfunction

    // Positive part of a sample, saturated to the threshold range.
    function automatic logic [TW-1:0] clip_pos(input logic [SB-1:0] x);
        logic [31:0] xz;
        xz = {{(32 - SB){1'b0}}, x};
        if (x[SB-1] || x == '0) begin
            return '0;
        end
        if (xz > 32'(eatq_pkg::PEAK_MAX)) begin
            return eatq_pkg::PEAK_MAX;
        end
        return xz[TW-1:0];
    endfunction

    logic [CW-1:0]                 r_alpha;
    logic [CW-1:0]                 r_gamma;
    logic [eatq_pkg::CMD_W-1:0]    r_cmd;
    logic [SB-1:0]                 r_sample;
    logic [SB-1:0]                 r_delay_mem [eatq_pkg::TRAIN_LEN];
    logic [SB-1:0]                 r_rd_data;
    logic [AW-1:0]                 r_head;
    logic [FW-1:0]                 r_fill;
    logic [TW-1:0]                 r_threshold;
    logic [TW-1:0]                 r_peak;
    logic [eatq_pkg::POS_W-1:0]    r_position;
    logic                          r_beat_found;
    logic                          r_training_done;
    logic                          r_out_valid;
    logic                          r_out_mark;
    logic [SB-1:0]                 r_out_sample;
    logic [TW-1:0]                 r_out_thr;
    logic                          r_out_end;
    logic [AGW-1:0]                r_prod_ag;
    logic [PTW-1:0]                r_prod_t;
    logic [PPW-1:0]                r_prod_p;

    logic [AW-1:0]  tail;
    logic           mem_we;
    logic [FW-1:0]  fill_inc;
    logic           line_full;
    logic           frame_close;
    logic           mark;
    logic [TW-1:0]  x_clip;
    logic [CW-1:0]  a_sat;
    logic [CW-1:0]  g_sat;
    logic [CW-1:0]  one_minus_a;
    logic [PPW:0]   upd_sum;
    logic [PPW-30:0] upd_thr;

    function automatic logic [TW-1:0] x_clip_push();
        return clip_pos(r_sample);
    endfunction

    assign tail        = ring_add(r_head, r_fill);
    assign fill_inc    = r_fill + FW'(1);
    assign line_full   = (r_fill >= FW'(eatq_pkg::TRAIN_LEN));
    assign frame_close = (r_position == eatq_pkg::POS_W'(eatq_pkg::FRAME_LEN - 1));
    assign x_clip      = clip_pos(r_rd_data);
    assign mark        = !r_beat_found
                         && ($signed({{(32 - SB){r_rd_data[SB-1]}}, r_rd_data})
                             > $signed({{(32 - TW){1'b0}}, r_threshold}));

    // When the line is full the tail equals the head, so a refill lands in
    // the slot that was just read out.
    assign mem_we = (i_cmd.train_push && !line_full) || i_cmd.append_push
                    || (i_cmd.emit && r_cmd == eatq_pkg::CMD_PUSH);

    assign a_sat       = (r_alpha > eatq_pkg::Q15_ONE) ? eatq_pkg::Q15_ONE : r_alpha;
    assign g_sat       = (r_gamma > eatq_pkg::Q15_ONE) ? eatq_pkg::Q15_ONE : r_gamma;
    assign one_minus_a = eatq_pkg::Q15_ONE - a_sat;
    assign upd_sum     = (PPW + 1)'(r_prod_p) + (PPW + 1)'({r_prod_t, 15'd0});
    assign upd_thr     = upd_sum[PPW:30];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_delay_mem[tail] <= r_sample;
        end
        if (i_cmd.mem_read) begin
            r_rd_data <= r_delay_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= eatq_pkg::ALPHA_RESET;
            r_gamma <= eatq_pkg::GAMMA_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                eatq_pkg::REG_ALPHA: r_alpha <= i_cfg_data;
                eatq_pkg::REG_GAMMA: r_gamma <= i_cfg_data;
                default: begin
                    r_alpha <= r_alpha;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd    <= i_s_axis_tuser;
            r_sample <= i_s_axis_tdata[SB-1:0];
        end
        if (i_cmd.mul_a) begin
            r_prod_ag <= AGW'(a_sat * g_sat);
            r_prod_t  <= PTW'(one_minus_a * r_threshold);
        end
        if (i_cmd.mul_b) begin
            r_prod_p <= PPW'(r_prod_ag * r_peak);
        end
        if (i_cmd.emit) begin
            r_out_mark   <= mark;
            r_out_sample <= r_rd_data;
            r_out_thr    <= r_threshold;
            r_out_end    <= frame_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head          <= '0;
            r_fill          <= '0;
            r_threshold     <= '0;
            r_peak          <= '0;
            r_position      <= '0;
            r_beat_found    <= 1'b0;
            r_training_done <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.clear) begin
                r_head          <= '0;
                r_fill          <= '0;
                r_threshold     <= '0;
                r_peak          <= '0;
                r_position      <= '0;
                r_beat_found    <= 1'b0;
                r_training_done <= 1'b0;
            end

            if (i_cmd.train_push) begin
                if (x_clip_push() > r_threshold) begin
                    r_threshold <= x_clip_push();
                end
                if (!line_full) begin
                    r_fill <= fill_inc;
                    if (fill_inc >= FW'(eatq_pkg::TRAIN_LEN)) begin
                        r_training_done <= 1'b1;
                    end
                end else begin
                    r_training_done <= 1'b1;
                end
            end

            if (i_cmd.append_push) begin
                r_fill <= fill_inc;
            end

            if (i_cmd.end_training) begin
                r_training_done <= 1'b1;
            end

            if (i_cmd.emit) begin
                r_head <= ring_add(r_head, FW'(1));
                if (r_cmd != eatq_pkg::CMD_PUSH) begin
                    r_fill <= r_fill - FW'(1);
                end
                if (mark) begin
                    r_beat_found <= 1'b1;
                end
                if (x_clip > r_peak) begin
                    r_peak <= x_clip;
                end
                if (!frame_close) begin
                    r_position <= r_position + eatq_pkg::POS_W'(1);
                end
            end

            if (i_cmd.update) begin
                r_threshold  <= (upd_thr > (PPW - 29)'(eatq_pkg::PEAK_MAX))
                                ? eatq_pkg::PEAK_MAX : upd_thr[TW-1:0];
                r_peak       <= '0;
                r_position   <= '0;
                r_beat_found <= 1'b0;
            end
        end
    end

    assign o_sts.command       = r_cmd;
    assign o_sts.line_empty    = (r_fill == '0);
    assign o_sts.line_full     = line_full;
    assign o_sts.training_done = r_training_done;
    assign o_sts.out_free      = !r_out_valid || i_m_axis_tready;
    assign o_sts.frame_close   = frame_close;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_mark;
    assign o_m_axis_tlast  = r_out_end;
    assign o_m_axis_tdata  = {{(eatq_pkg::OUT_TDATA_W - eatq_pkg::SAMPLE_FIELD_W - TW){1'b0}},
                              r_out_thr,
                              eatq_pkg::SAMPLE_FIELD_W'($signed(r_out_sample))};

endmodule

@@ rtl/ecg_adaptive_threshold_qrs_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive threshold QRS marker: top level
// Use: push filtered ECG samples on the slave stream (tuser = command,
// tdata = sample). For the first 256 samples of a record the block only
// stores them and learns the starting threshold from their positive peak.
// After that each push returns the sample from 256 pushes earlier on the
// master stream with its beat mark (tuser), the threshold it was judged
// against (tdata[30:16]) and tlast on the last sample of a 256-sample frame.
// Drain commands flush the delay line at the end of a record; a new-record
// command clears the record state. alpha and gamma are written on the cfg
// channel, index 0 and 1, while no beat is in flight.
// Sequence: a push during training, an append or a control command only
// passes decode; a beat that reads the delay line passes decode and emit,
// and a frame close adds the two threshold multiplies and the update step.
// The delay line is a single-port ring buffer read once per emitted beat.
// Reset clears the record state and loads the default coefficients; the
// line needs no clearing pass. If the receiver stalls, one finished beat
// waits in the output register and the next input is still taken; a second
// result then waits in the emit step until the output register frees.
// ----------------------------------------------------------------------------
module ecg_adaptive_threshold_qrs_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [eatq_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // [15:0] sample_value
    input  logic [eatq_pkg::CMD_W-1:0]         i_s_axis_tuser,  // [1:0] command
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [15:0] delayed_sample, [30:16] threshold_now, [31] zero
    output logic [eatq_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                               o_m_axis_tuser,  // [0] beat_mark
    output logic                               o_m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [eatq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [eatq_pkg::COEF_W-1:0]        i_cfg_data
);

    eatq_pkg::t_dp_cmd dp_cmd;
    eatq_pkg::t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    eatq_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (dp_sts),
        .o_cmd           (dp_cmd)
    );

    eatq_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts)
    );

endmodule

@@ rtl/eatq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive threshold QRS marker: port checker
// Watches the top-level ports for stream and sequencing rules over time.
// ----------------------------------------------------------------------------
module eatq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [eatq_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input logic                               o_m_axis_tuser,
    input logic                               o_m_axis_tlast
);

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("output beat changed while stalled");

    // Reset leaves no output beat pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // An accepted input is decoded before any new input can be taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while previous beat is decoded");

    // A result never appears in the cycle right after its input was taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("output beat without emit step");

endmodule

bind ecg_adaptive_threshold_qrs_core eatq_checker u_eatq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
